// ----- design/ffba_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  // Default geometry of the allocator.
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_ADDR_BITS  = 20;
  localparam int DEF_OWNER_BITS = 8;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQ   = 2'd1;

  // Register values after reset.
  localparam int RESET_TOTAL = 16384;
  localparam int RESET_REQ   = 4096;

  // Command codes.
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Status codes.
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [ST_W-1:0] ST_NOOWNER = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  // Control strobes from the sequencer to the block table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic rebuild;
  } tbl_ctl_t;

endpackage

// ----- design/ffba_if.sv -----
// Valid/ready channel interfaces for request items and result items.
interface ffba_in_if #(
  parameter int OWNER_BITS = ffba_pkg::DEF_OWNER_BITS
);
  logic                        valid;
  logic                        ready;
  logic [ffba_pkg::CMD_W-1:0]  command;
  logic [OWNER_BITS-1:0]       process_id;

  modport source (output valid, output command, output process_id, input ready);
  modport sink   (input valid, input command, input process_id, output ready);
endinterface

interface ffba_out_if #(
  parameter int ADDR_BITS = ffba_pkg::DEF_ADDR_BITS
);
  logic                       valid;
  logic                       ready;
  logic [ffba_pkg::ST_W-1:0]  status;
  logic [ADDR_BITS-1:0]       base_address;
  logic [ADDR_BITS:0]         fragment_bytes;

  modport source (output valid, output status, output base_address, output fragment_bytes,
                  input ready);
  modport sink   (input valid, input status, input base_address, input fragment_bytes,
                  output ready);
endinterface

// ----- design/ffba_table.sv -----
// Block table memory with one read and one write port and a rebuilt-entry override.
module ffba_table #(
  parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = ffba_pkg::DEF_ADDR_BITS,
  parameter int OWNER_BITS = ffba_pkg::DEF_OWNER_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffba_pkg::tbl_ctl_t            ctl,
  input  logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
  input  logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
  input  logic [ADDR_BITS-1:0]          w_start,
  input  logic [ADDR_BITS:0]            w_len,
  input  logic                          w_free,
  input  logic [OWNER_BITS-1:0]         w_owner,
  input  logic [ADDR_BITS:0]            total,
  output logic [ADDR_BITS-1:0]          r_start,
  output logic [ADDR_BITS:0]            r_len,
  output logic                          r_free,
  output logic [OWNER_BITS-1:0]         r_owner
);
  import ffba_pkg::*;

  localparam int LEN_W = ADDR_BITS + 1;
  localparam int ENT_W = ADDR_BITS + LEN_W + 1 + OWNER_BITS;

  logic [ENT_W-1:0] mem [MAX_BLOCKS];
  logic [ENT_W-1:0] rd_q_r;
  logic             ovr_r;
  logic             rd_ovr_r;

  // Entry 0 reads as one free block of the whole memory until it is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_r <= 1'b1;
    end else if (ctl.rebuild) begin
      ovr_r <= 1'b1;
    end else if (ctl.wr_en && wr_addr == '0) begin
      ovr_r <= 1'b0;
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {w_start, w_len, w_free, w_owner};
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_ovr_r <= ovr_r && (rd_addr == '0);
    end
  end

  // Unpack the read entry, or the rebuilt entry 0.
  always_comb begin
    if (rd_ovr_r) begin
      r_start = '0;
      r_len   = total;
      r_free  = 1'b1;
      r_owner = '0;
    end else begin
      {r_start, r_len, r_free, r_owner} = rd_q_r;
    end
  end

endmodule

// ----- design/first_fit_block_allocator_core.sv -----
// First-fit block allocator: request sequencer over a block table with one read and one write port.
// A query or a miss scans every entry; an allocate or a free stops the scan at the hit, and the
// entry shift covers only the entries after it, one entry per cycle. One item is in work at a
// time, and a result waits while the output is stalled; the next item is accepted in the cycle
// after the result is registered. Reset (synchronous, active low) leaves one free block of
// 16384 bytes, no clearing pass.
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = ffba_pkg::DEF_ADDR_BITS,
  parameter int OWNER_BITS = ffba_pkg::DEF_OWNER_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ffba_in_if.sink                           in_ch,
  ffba_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W = ADDR_BITS + 1;
  localparam int CW    = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_AWR1  = 4'd3;
  localparam logic [3:0] S_AWR0  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FNX   = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Clamp a size to 1 .. 2^ADDR_BITS.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [CW-1:0] v);
    logic [CW-1:0] top;
    top = CW'(1) << ADDR_BITS;
    if (v == '0) begin
      return LEN_W'(1);
    end else if (v > top) begin
      return LEN_W'(top);
    end
    return LEN_W'(v);
  endfunction

  logic [3:0]            state_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [OWNER_BITS-1:0] pid_r;
  logic [LEN_W-1:0]      total_r;
  logic [LEN_W-1:0]      req_r;
  logic [CNT_W-1:0]      cnt_r;

  logic [CNT_W-1:0]      rd_idx_r;
  logic                  dv_r;
  logic [IDX_W-1:0]      d_idx_r;

  logic [IDX_W-1:0]      hit_idx_r;
  logic [ADDR_BITS-1:0]  rec_start_r;
  logic [LEN_W-1:0]      rec_len_r;
  logic [ADDR_BITS-1:0]  prv_start_r;
  logic [LEN_W-1:0]      prv_len_r;
  logic                  prv_free_r;
  logic                  pf_r;
  logic                  nf_r;
  logic [LEN_W-1:0]      acc_r;

  logic [IDX_W-1:0]      sh_src_r;
  logic [IDX_W-1:0]      sh_last_r;
  logic                  sh_up_r;
  logic [1:0]            sh_d_r;
  logic                  sh_iss_done_r;
  logic                  sh_dv_r;
  logic [IDX_W-1:0]      sh_didx_r;
  logic [3:0]            sh_next_r;

  logic [ST_W-1:0]       res_status_r;
  logic [ADDR_BITS-1:0]  res_base_r;
  logic [LEN_W-1:0]      res_frag_r;

  logic                  out_valid_r;
  logic [ST_W-1:0]       out_status_r;
  logic [ADDR_BITS-1:0]  out_base_r;
  logic [LEN_W-1:0]      out_frag_r;

  tbl_ctl_t              tbl_ctl;
  logic [IDX_W-1:0]      tbl_rd_addr;
  logic [IDX_W-1:0]      tbl_wr_addr;
  logic [ADDR_BITS-1:0]  tbl_w_start;
  logic [LEN_W-1:0]      tbl_w_len;
  logic                  tbl_w_free;
  logic [OWNER_BITS-1:0] tbl_w_owner;
  logic [ADDR_BITS-1:0]  rd_start;
  logic [LEN_W-1:0]      rd_len;
  logic                  rd_free;
  logic [OWNER_BITS-1:0] rd_owner;

  logic [CNT_W-1:0]      cnt_m1;
  logic                  scan_hit;
  logic                  scan_last;
  logic                  frag_hit;
  logic [LEN_W-1:0]      acc_add;
  logic [CNT_W-1:0]      hit_nxt;
  logic [CNT_W-1:0]      sh_lo;
  logic [1:0]            merge_d;
  logic                  in_acc;
  logic                  out_free;

  ffba_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .rd_addr (tbl_rd_addr),
    .wr_addr (tbl_wr_addr),
    .w_start (tbl_w_start),
    .w_len   (tbl_w_len),
    .w_free  (tbl_w_free),
    .w_owner (tbl_w_owner),
    .total   (total_r),
    .r_start (rd_start),
    .r_len   (rd_len),
    .r_free  (rd_free),
    .r_owner (rd_owner)
  );

  // Scan decisions on the entry that the table returns this cycle.
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign scan_last = dv_r && (CNT_W'(d_idx_r) == cnt_m1);
  assign frag_hit  = dv_r && (cmd_r == CMD_QUERY) && rd_free && (rd_len < req_r);
  assign acc_add   = acc_r + (frag_hit ? rd_len : '0);
  assign hit_nxt   = CNT_W'(d_idx_r) + CNT_W'(1);
  assign sh_lo     = CNT_W'(hit_idx_r) + CNT_W'(1) + CNT_W'(nf_r);
  assign merge_d   = {1'b0, nf_r} + {1'b0, pf_r};

  always_comb begin
    scan_hit = 1'b0;
    if (dv_r) begin
      case (cmd_r)
        CMD_ALLOC: scan_hit = rd_free && (rd_len >= req_r);
        CMD_FREE:  scan_hit = !rd_free && (rd_owner == pid_r);
        default:   scan_hit = 1'b0;
      endcase
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Table port control for each state.
  always_comb begin
    tbl_ctl         = '0;
    tbl_ctl.rebuild = cfg_we && (cfg_index == REG_TOTAL);
    tbl_rd_addr     = rd_idx_r[IDX_W-1:0];
    tbl_wr_addr     = hit_idx_r;
    tbl_w_start     = rd_start;
    tbl_w_len       = rd_len;
    tbl_w_free      = rd_free;
    tbl_w_owner     = rd_owner;
    unique case (state_r)
      S_SCAN: begin
        tbl_ctl.rd_en = (rd_idx_r < cnt_r) && !scan_hit && !scan_last;
      end
      S_SHIFT: begin
        tbl_ctl.rd_en = !sh_iss_done_r;
        tbl_rd_addr   = sh_src_r;
        tbl_ctl.wr_en = sh_dv_r;
        tbl_wr_addr   = sh_up_r ? (sh_didx_r + IDX_W'(1)) : (sh_didx_r - IDX_W'(sh_d_r));
      end
      S_AWR1: begin
        tbl_ctl.wr_en = 1'b1;
        tbl_wr_addr   = hit_idx_r + IDX_W'(1);
        tbl_w_start   = rec_start_r + ADDR_BITS'(req_r);
        tbl_w_len     = rec_len_r - req_r;
        tbl_w_free    = 1'b1;
        tbl_w_owner   = '0;
      end
      S_AWR0: begin
        tbl_ctl.wr_en = 1'b1;
        tbl_w_start   = rec_start_r;
        tbl_w_len     = req_r;
        tbl_w_free    = 1'b0;
        tbl_w_owner   = pid_r;
      end
      S_FRD: begin
        tbl_ctl.rd_en = 1'b1;
        tbl_rd_addr   = hit_idx_r + IDX_W'(1);
      end
      S_FWR: begin
        tbl_ctl.wr_en = 1'b1;
        tbl_wr_addr   = pf_r ? (hit_idx_r - IDX_W'(1)) : hit_idx_r;
        tbl_w_start   = pf_r ? prv_start_r : rec_start_r;
        tbl_w_len     = acc_r + (pf_r ? prv_len_r : '0);
        tbl_w_free    = 1'b1;
        tbl_w_owner   = '0;
      end
      S_IDLE, S_FNX, S_DONE: begin
        tbl_ctl.rd_en = 1'b0;
      end
      default: begin
        tbl_ctl.rd_en = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= clamp_len(CW'(RESET_TOTAL));
      req_r   <= clamp_len(CW'(RESET_REQ));
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL: total_r <= clamp_len(CW'(cfg_data));
        REG_REQ:   req_r   <= clamp_len(CW'(cfg_data));
        default:   ;
      endcase
    end
  end

  // Block count: one after a rebuild, up on a split, down by the merged entries on a free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(1);
    end else if (cfg_we && cfg_index == REG_TOTAL) begin
      cnt_r <= CNT_W'(1);
    end else if (state_r == S_AWR1) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (state_r == S_FWR) begin
      cnt_r <= cnt_r - CNT_W'(merge_d);
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      dv_r          <= 1'b0;
      sh_dv_r       <= 1'b0;
      sh_iss_done_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r        <= in_ch.command;
            pid_r        <= in_ch.process_id;
            rd_idx_r     <= '0;
            dv_r         <= 1'b0;
            acc_r        <= '0;
            res_status_r <= ST_OK;
            res_base_r   <= '0;
            res_frag_r   <= '0;
            if (in_ch.command == CMD_ALLOC || in_ch.command == CMD_FREE ||
                in_ch.command == CMD_QUERY) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          // The read stops on a hit or on the last entry, so the data valid flag clears then.
          dv_r    <= tbl_ctl.rd_en;
          d_idx_r <= rd_idx_r[IDX_W-1:0];
          if (tbl_ctl.rd_en) begin
            rd_idx_r <= rd_idx_r + CNT_W'(1);
          end
          if (dv_r && !scan_hit) begin
            prv_start_r <= rd_start;
            prv_len_r   <= rd_len;
            prv_free_r  <= rd_free;
            acc_r       <= acc_add;
          end
          if (scan_hit) begin
            hit_idx_r   <= d_idx_r;
            rec_start_r <= rd_start;
            rec_len_r   <= rd_len;
            if (cmd_r == CMD_ALLOC) begin
              if (rd_len > req_r) begin
                if (cnt_r == CNT_W'(MAX_BLOCKS)) begin
                  res_status_r <= ST_FULL;
                  state_r      <= S_DONE;
                end else if (hit_nxt < cnt_r) begin
                  // Open a slot after the hit by moving later entries up by one.
                  sh_src_r      <= cnt_m1[IDX_W-1:0];
                  sh_last_r     <= hit_nxt[IDX_W-1:0];
                  sh_up_r       <= 1'b1;
                  sh_d_r        <= 2'd1;
                  sh_iss_done_r <= 1'b0;
                  sh_dv_r       <= 1'b0;
                  sh_next_r     <= S_AWR1;
                  state_r       <= S_SHIFT;
                end else begin
                  state_r <= S_AWR1;
                end
              end else begin
                state_r <= S_AWR0;
              end
            end else begin
              res_base_r <= rd_start;
              acc_r      <= rd_len;
              pf_r       <= (d_idx_r != '0) && prv_free_r;
              if (hit_nxt < cnt_r) begin
                state_r <= S_FRD;
              end else begin
                nf_r    <= 1'b0;
                state_r <= S_FWR;
              end
            end
          end else if (scan_last) begin
            case (cmd_r)
              CMD_ALLOC: res_status_r <= ST_NOFIT;
              CMD_FREE:  res_status_r <= ST_NOOWNER;
              default:   res_frag_r   <= acc_add;
            endcase
            state_r <= S_DONE;
          end
        end
        S_SHIFT: begin
          // The last read is issued before the last write, so the valid flag clears then.
          sh_dv_r   <= tbl_ctl.rd_en;
          sh_didx_r <= sh_src_r;
          if (tbl_ctl.rd_en) begin
            if (sh_src_r == sh_last_r) begin
              sh_iss_done_r <= 1'b1;
            end else begin
              sh_src_r <= sh_up_r ? (sh_src_r - IDX_W'(1)) : (sh_src_r + IDX_W'(1));
            end
          end
          if (sh_dv_r && sh_didx_r == sh_last_r) begin
            state_r <= sh_next_r;
          end
        end
        S_AWR1: begin
          state_r <= S_AWR0;
        end
        S_AWR0: begin
          res_base_r <= rec_start_r;
          state_r    <= S_DONE;
        end
        S_FRD: begin
          state_r <= S_FNX;
        end
        S_FNX: begin
          nf_r <= rd_free;
          if (rd_free) begin
            acc_r <= acc_r + rd_len;
          end
          state_r <= S_FWR;
        end
        S_FWR: begin
          if (merge_d != 2'd0 && sh_lo <= cnt_m1) begin
            // Close the gap left by merged entries by moving later entries down.
            sh_src_r      <= sh_lo[IDX_W-1:0];
            sh_last_r     <= cnt_m1[IDX_W-1:0];
            sh_up_r       <= 1'b0;
            sh_d_r        <= merge_d;
            sh_iss_done_r <= 1'b0;
            sh_dv_r       <= 1'b0;
            sh_next_r     <= S_DONE;
            state_r       <= S_SHIFT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_base_r   <= res_base_r;
      out_frag_r   <= res_frag_r;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.base_address   = out_base_r;
  assign out_ch.fragment_bytes = out_frag_r;

  // The table always holds between one and MAX_BLOCKS entries.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  // The table is only written while a request is in work.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !tbl_ctl.wr_en)
    else $error("table write while idle");

  // A split with a full table reports table full and leaves the count alone.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_hit && cmd_r == CMD_ALLOC && rd_len > req_r &&
     cnt_r == CNT_W'(MAX_BLOCKS))
    |=> (res_status_r == ST_FULL) && (state_r == S_DONE) && $stable(cnt_r))
    else $error("full table split not refused");

endmodule

// ----- verif/first_fit_block_allocator_core_test.sv -----
// Self-checking testbench for the first-fit block allocator core.
`timescale 1ns / 100ps

module first_fit_block_allocator_core_test;
  import ffba_pkg::*;

  localparam int MAXB       = DEF_MAX_BLOCKS;
  localparam int TOP_SIZE   = 1 << DEF_ADDR_BITS;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 200;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [DEF_ADDR_BITS-1:0] base;
    logic [DEF_ADDR_BITS:0]   frag;
  } alloc_result_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic [DEF_OWNER_BITS-1:0] pid;
    bit                        typed;
    alloc_result_t             res;
  } stim_row_t;

  typedef struct {
    bit wr_total;
    int total;
    int req;
    int n;
    int alloc_pct;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ffba_in_if  in_ch ();
  ffba_out_if out_ch ();

  first_fit_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block table and registers.
  int unsigned blk_start [MAXB];
  int unsigned blk_len [MAXB];
  bit          blk_free [MAXB];
  logic [7:0]  blk_owner [MAXB];
  int          blk_cnt;
  int unsigned total_sz;
  int unsigned req_sz;

  alloc_result_t pending_results[$];
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_seen = 0;
  int hold_cycles = 0;
  int ready_mode = 0;
  int idle_count = 0;

  function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > TOP_SIZE) return TOP_SIZE;
    return v;
  endfunction

  function automatic void rebuild_table();
    for (int j = 0; j < MAXB; j++) begin
      blk_start[j] = 0;
      blk_len[j] = 0;
      blk_free[j] = 0;
      blk_owner[j] = 0;
    end
    blk_len[0] = total_sz;
    blk_free[0] = 1;
    blk_cnt = 1;
  endfunction

  // Drop entry idx and close the gap.
  function automatic void remove_block(input int idx);
    for (int k = idx; k + 1 < blk_cnt; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_len[k] = blk_len[k+1];
      blk_free[k] = blk_free[k+1];
      blk_owner[k] = blk_owner[k+1];
    end
    blk_cnt--;
  endfunction

  // Compute the result of one item and update the shadow table.
  function automatic alloc_result_t predict_alloc(input logic [CMD_W-1:0] cmd,
                                                  input logic [7:0] pid);
    alloc_result_t r;
    bit done;
    int unsigned sum;
    r = '0;
    done = 0;
    sum = 0;
    case (cmd)
      CMD_ALLOC: begin
        r.status = ST_NOFIT;
        for (int i = 0; i < blk_cnt && !done; i++) begin
          if (blk_free[i] && blk_len[i] >= req_sz) begin
            done = 1;
            if (blk_len[i] > req_sz && blk_cnt >= MAXB) begin
              r.status = ST_FULL;
            end else begin
              if (blk_len[i] > req_sz) begin
                for (int k = blk_cnt; k > i + 1; k--) begin
                  blk_start[k] = blk_start[k-1];
                  blk_len[k] = blk_len[k-1];
                  blk_free[k] = blk_free[k-1];
                  blk_owner[k] = blk_owner[k-1];
                end
                blk_start[i+1] = blk_start[i] + req_sz;
                blk_len[i+1] = blk_len[i] - req_sz;
                blk_free[i+1] = 1;
                blk_owner[i+1] = 0;
                blk_len[i] = req_sz;
                blk_cnt++;
              end
              blk_free[i] = 0;
              blk_owner[i] = pid;
              r.status = ST_OK;
              r.base = blk_start[i][DEF_ADDR_BITS-1:0];
            end
          end
        end
      end
      CMD_FREE: begin
        r.status = ST_NOOWNER;
        for (int i = 0; i < blk_cnt && !done; i++) begin
          if (!blk_free[i] && blk_owner[i] == pid) begin
            done = 1;
            r.status = ST_OK;
            r.base = blk_start[i][DEF_ADDR_BITS-1:0];
            blk_free[i] = 1;
            blk_owner[i] = 0;
            if (i + 1 < blk_cnt && blk_free[i+1]) begin
              blk_len[i] += blk_len[i+1];
              remove_block(i + 1);
            end
            if (i > 0 && blk_free[i-1]) begin
              blk_len[i-1] += blk_len[i];
              remove_block(i);
            end
          end
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < blk_cnt; i++)
          if (blk_free[i] && blk_len[i] < req_sz) sum += blk_len[i];
        r.frag = sum[DEF_ADDR_BITS:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Write one register while the block is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_TOTAL) begin
      total_sz = clamp_size(v);
      rebuild_table();
    end else if (idx == REG_REQ) begin
      req_sz = clamp_size(v);
    end
  endtask

  // Offer one item and hold it until the block takes it, then maybe pause.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] pid,
                           input bit typed, input alloc_result_t typed_res, input int gap);
    alloc_result_t r;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.process_id = pid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_alloc(cmd, pid);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: long hold when asked, else the current stall pattern.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      case (ready_mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 99) < 65);
        default: out_ch.ready = ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_FULL) full_seen++;
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.base_address !== want.base)
          report_mismatch($sformatf("base_address %0h, expected %0h",
                                    out_ch.base_address, want.base));
        if (out_ch.fragment_bytes !== want.frag)
          report_mismatch($sformatf("fragment_bytes %0d, expected %0d",
                                    out_ch.fragment_bytes, want.frag));
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count == IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  stim_row_t dir_rows[$];
  phase_t phases[$];

  function automatic stim_row_t mk_row(input logic [CMD_W-1:0] c, input logic [7:0] p,
                                       input bit t, input logic [ST_W-1:0] s,
                                       input int b, input int f);
    stim_row_t row;
    row.cmd = c;
    row.pid = p;
    row.typed = t;
    row.res.status = s;
    row.res.base = DEF_ADDR_BITS'(b);
    row.res.frag = (DEF_ADDR_BITS + 1)'(f);
    return row;
  endfunction

  function automatic phase_t mk_phase(input bit w, input int t, input int rq, input int n,
                                      input int ap);
    phase_t ph;
    ph.wr_total = w;
    ph.total = t;
    ph.req = rq;
    ph.n = n;
    ph.alloc_pct = ap;
    return ph;
  endfunction

  initial begin
    int burst;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [7:0] pid;

    in_ch.valid = 1'b0;
    in_ch.command = CMD_ALLOC;
    in_ch.process_id = '0;
    out_ch.ready = 1'b0;
    total_sz = RESET_TOTAL;
    req_sz = RESET_REQ;
    rebuild_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items from the state after reset: four 4096-byte slots.
    dir_rows.insert(dir_rows.size(), mk_row(CMD_ALLOC, 8'd0,   1, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_ALLOC, 8'd255, 1, ST_OK, 4096, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_QUERY, 8'd85,  1, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_FREE,  8'd9,   1, ST_NOOWNER, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_NONE,  8'd170, 1, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_FREE,  8'd0,   1, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_ALLOC, 8'd1,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_ALLOC, 8'd2,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_ALLOC, 8'd3,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_ALLOC, 8'd4,   1, ST_NOFIT, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_FREE,  8'd255, 0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_FREE,  8'd2,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_QUERY, 8'd0,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_FREE,  8'd1,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_FREE,  8'd3,   0, ST_OK, 0, 0));
    dir_rows.insert(dir_rows.size(), mk_row(CMD_QUERY, 8'd255, 0, ST_OK, 0, 0));
    ready_mode = 0;
    foreach (dir_rows[r])
      send_item(dir_rows[r].cmd, dir_rows[r].pid, dir_rows[r].typed, dir_rows[r].res, 0);

    // Random phases over a spread of sizes, extremes included.
    phases.insert(phases.size(), mk_phase(1, TOP_SIZE, 1, 200, 85));
    phases.insert(phases.size(), mk_phase(1, 2097151, 65536, 100, 50));
    phases.insert(phases.size(), mk_phase(1, 5000, 300, 120, 50));
    phases.insert(phases.size(), mk_phase(0, 0, 700, 80, 45));
    phases.insert(phases.size(), mk_phase(1, 1, 1, 40, 45));
    phases.insert(phases.size(), mk_phase(1, 0, 0, 30, 45));
    phases.insert(phases.size(), mk_phase(1, TOP_SIZE, TOP_SIZE, 30, 45));
    phases.insert(phases.size(),
                  mk_phase(1, $urandom_range(1, 4000), $urandom_range(1, 600), 80, 50));
    phases.insert(phases.size(),
                  mk_phase(1, $urandom_range(1, 100000), $urandom_range(1, 9000), 80, 50));

    foreach (phases[p]) begin
      wait_drained();
      if (phases[p].wr_total) cfg_write(REG_TOTAL, CFG_DATA_W'(phases[p].total));
      cfg_write(REG_REQ, CFG_DATA_W'(phases[p].req));
      if (p == 2) cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 2097151)));
      if (p == 3) cfg_write(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 2097151)));
      ready_mode = p % 3;
      if (p == 0) hold_cycles = 400;
      burst = 0;
      for (int n = 0; n < phases[p].n; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < phases[p].alloc_pct) cmd = CMD_ALLOC;
        else if (pick < 90) cmd = CMD_FREE;
        else if (pick < 97) cmd = CMD_QUERY;
        else cmd = CMD_NONE;
        pid = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 15));
        if (burst == 0) burst = $urandom_range(1, 12);
        burst--;
        send_item(cmd, pid, 0, '0, (burst == 0) ? $urandom_range(1, 8) : 0);
      end
    end

    wait_drained();
    $display("Covered %0d items and %0d results over %0d register settings.",
             items_sent, results_seen, phases.size() + 1);
    $display("Table-full refusals seen: %0d; stall patterns and a long receiver hold used.",
             full_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ffba_pkg.sv
design/ffba_if.sv
design/ffba_table.sv
design/first_fit_block_allocator_core.sv
verif/first_fit_block_allocator_core_test.sv
